[hw/rtl/ppt_pkg.sv]
`default_nettype none

package ppt_pkg;

  // CORDIC datapath width: normalized vectors below 2^32 grow by the gain and sqrt(2)
  localparam int CW = 36;
  localparam int ATAN_LEN = 24;

  // start value of x in rotation, inverse of the infinite-step gain in Q30
  localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sh026DD3B6A;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) as a 32-bit binary angle
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [2:0] {
    MODE_L2W    = 3'd0,
    MODE_W2L    = 3'd1,
    MODE_INTERP = 3'd2,
    MODE_INV    = 3'd3,
    MODE_LOOKAT = 3'd4
  } mode_e;

  // working set of one CORDIC stage; look-at runs in vectoring mode
  typedef struct packed {
    mode_e                 mode;
    logic                  flip;
    logic                  zero;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic [31:0]           z;
  } cordic_t;

  // operands that ride alongside the CORDIC
  typedef struct packed {
    logic signed [32:0] p;
    logic signed [32:0] q;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [15:0]        t;
    logic [15:0]        hd;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/ppt_cordic.sv]
`default_nettype none

module ppt_cordic import ppt_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    vld_i,
  input  cordic_t cor_i,
  input  side_t   side_i,
  output logic    vld_o,
  output cordic_t cor_o,
  output side_t   side_o
);

  cordic_t              stg_in [STEPS];
  cordic_t              cor_d  [STEPS];
  cordic_t              cor_q  [STEPS];
  side_t                side_q [STEPS];
  logic signed [CW-1:0] xs     [STEPS];
  logic signed [CW-1:0] ys     [STEPS];
  logic [STEPS-1:0]     neg;
  logic [STEPS-1:0]     vld_q;

  // one micro-rotation per stage, shift fixed by stage position
  always_comb begin
    stg_in[0] = cor_i;
    for (int i = 1; i < STEPS; i++) begin
      stg_in[i] = cor_q[i-1];
    end
    for (int i = 0; i < STEPS; i++) begin
      xs[i] = $signed(stg_in[i].x) >>> i;
      ys[i] = $signed(stg_in[i].y) >>> i;
      if (stg_in[i].mode == MODE_LOOKAT) begin
        neg[i] = !stg_in[i].y[CW-1] && (stg_in[i].y != '0);
      end else begin
        neg[i] = stg_in[i].z[31];
      end
      cor_d[i] = stg_in[i];
      if (neg[i]) begin
        cor_d[i].x = stg_in[i].x + ys[i];
        cor_d[i].y = stg_in[i].y - xs[i];
        cor_d[i].z = stg_in[i].z + ATAN_TAB[i];
      end else begin
        cor_d[i].x = stg_in[i].x - ys[i];
        cor_d[i].y = stg_in[i].y + xs[i];
        cor_d[i].z = stg_in[i].z - ATAN_TAB[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 0; i < STEPS; i++) begin
        cor_q[i] <= cor_d[i];
      end
      for (int i = 1; i < STEPS; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign vld_o  = vld_q[STEPS-1];
  assign cor_o  = cor_q[STEPS-1];
  assign side_o = side_q[STEPS-1];

endmodule

`default_nettype wire

[hw/rtl/planar_pose_transform_unit.sv]
`default_nettype none

// Planar pose transform unit: composes two SE(2) poses A and B.
// Input channel: in_valid_i / in_stall_o carry one word with mode, pose A, pose B
// and the blend fraction. Output channel: out_valid_o / out_stall_i carry one
// word with r_x, r_y, r_heading and overflow. Every input word gives exactly
// one output word, in order.
// Modes: local-to-world, world-to-local, interpolate, inverse, look-at; unused
// mode codes give an all-zero result.
// Pipeline: one input register, four setup stages (vector prep, magnitude, two
// normalize stages), one CORDIC stage per iteration, four back-end stages (sin/cos
// rounding, multiply, sum and round, add and saturate) and the output register.
// Throughput: one word per cycle while the skid is empty; the CORDIC is fully
// unrolled and shared by rotation (sin/cos) and vectoring (atan2).
// Stall: a one-word skid register behind the pipeline tail takes the tail
// word while the output is held; in_stall_o rises only when the skid is full,
// and the whole pipeline holds until the skid drains.
// Reset: clears every valid bit; nothing in flight survives.

module planar_pose_transform_unit import ppt_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [15:0] a_heading_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [15:0] b_heading_i,
  input  logic [15:0]        blend_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] r_x_o,
  output logic signed [31:0] r_y_o,
  output logic signed [15:0] r_heading_o,
  output logic               overflow_o
);

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [15:0]        hd;
    logic               ov;
  } res_t;

  localparam logic signed [37:0] POS_MAX = 38'sd2147483647;
  localparam logic signed [37:0] POS_MIN = -38'sd2147483648;

  logic en;

  // stage 1: input register
  logic               s1_vld_q;
  mode_e              s1_mode_q;
  logic signed [31:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic signed [15:0] s1_ah_q, s1_dh_q, s1_hs_q;
  logic [15:0]        s1_t_q;
  logic signed [32:0] s1_dx_q, s1_dy_q;

  // stages 2..5: setup
  logic               s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  cordic_t            s2_cor_d, s2_cor_q, s3_cor_q, s4_cor_d, s4_cor_q, s5_cor_d, s5_cor_q;
  side_t              s2_side_d, s2_side_q, s3_side_d, s3_side_q, s4_side_q, s5_side_q;
  logic signed [15:0] s2_ah_q;
  logic signed [32:0] s2_tdh_d, s2_tdh_q;
  logic [31:0]        s3_m_d, s3_m_q, s4_m_d, s4_m_q, s5_m_d;
  logic signed [32:0] vdx, vdy;
  logic               flip;
  logic [31:0]        zr;
  logic signed [CW-1:0] absy;
  logic signed [33:0] hrnd;

  // CORDIC
  logic    cr_vld;
  cordic_t cr_cor;
  side_t   cr_side;

  // back end
  logic               c1_vld_q, c2_vld_q, c3_vld_q, tail_vld_q;
  mode_e              c1_mode_q, c2_mode_q, c3_mode_q;
  side_t              c1_side_d, c1_side_q, c2_side_q, c3_side_q;
  logic signed [29:0] c1_c_d, c1_c_q, c1_s_d, c1_s_q;
  logic signed [CW-1:0] xf, yf, cv, sv;
  logic [31:0]        zs;
  logic signed [62:0] c2_cp_q, c2_sq_q, c2_sp_q, c2_cq_q;
  logic signed [63:0] xsum, ysum, xacc, yacc;
  logic signed [35:0] c3_xr_d, c3_xr_q, c3_yr_d, c3_yr_q;
  logic signed [37:0] rxw, ryw;
  res_t               tail_d, tail_q, out_q, skid_q;
  logic               out_vld_q, skid_vld_q, take;

  // hold the whole pipeline while the skid word waits
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // ---------------- stage 1: capture, form differences ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mode_q <= mode_e'(mode_i);
      s1_ax_q   <= a_x_i;
      s1_ay_q   <= a_y_i;
      s1_bx_q   <= b_x_i;
      s1_by_q   <= b_y_i;
      s1_ah_q   <= a_heading_i;
      s1_dh_q   <= b_heading_i - a_heading_i;
      s1_hs_q   <= a_heading_i + b_heading_i;
      s1_t_q    <= blend_i;
      s1_dx_q   <= 33'(b_x_i) - 33'(a_x_i);
      s1_dy_q   <= 33'(b_y_i) - 33'(a_y_i);
    end
  end

  // ---------------- stage 2: pick operands, seed the CORDIC ----------------
  always_comb begin
    vdx  = s1_dx_q[32] ? -s1_dx_q : s1_dx_q;
    vdy  = s1_dx_q[32] ? -s1_dy_q : s1_dy_q;
    // fold headings beyond a quarter turn and negate the result later
    flip = (s1_ah_q > 16'sd16384) || (s1_ah_q < -16'sd16384);
    zr   = flip ? {~s1_ah_q[15], s1_ah_q[14:0], 16'h0000} : {s1_ah_q, 16'h0000};

    s2_cor_d.mode = s1_mode_q;
    s2_cor_d.flip = flip;
    s2_cor_d.zero = (s1_dx_q == '0) && (s1_dy_q == '0);
    if (s1_mode_q == MODE_LOOKAT) begin
      s2_cor_d.x = CW'(vdx);
      s2_cor_d.y = CW'(vdy);
      s2_cor_d.z = s1_dx_q[32] ? HALF_TURN : 32'h0;
    end else begin
      s2_cor_d.x = CORDIC_GAIN;
      s2_cor_d.y = '0;
      s2_cor_d.z = zr;
    end

    s2_side_d.ax = s1_ax_q;
    s2_side_d.ay = s1_ay_q;
    s2_side_d.t  = s1_t_q;
    case (s1_mode_q)
      MODE_L2W: begin
        s2_side_d.p  = 33'(s1_bx_q);
        s2_side_d.q  = 33'(s1_by_q);
        s2_side_d.hd = s1_hs_q;
      end
      MODE_W2L: begin
        s2_side_d.p  = s1_dx_q;
        s2_side_d.q  = s1_dy_q;
        s2_side_d.hd = s1_dh_q;
      end
      MODE_INV: begin
        s2_side_d.p  = 33'(s1_ax_q);
        s2_side_d.q  = 33'(s1_ay_q);
        s2_side_d.hd = -s1_ah_q;
      end
      default: begin
        s2_side_d.p  = s1_dx_q;
        s2_side_d.q  = s1_dy_q;
        s2_side_d.hd = 16'h0000;
      end
    endcase

    // heading step for interpolation: blend times the shorter arc
    s2_tdh_d = 33'($signed({1'b0, s1_t_q})) * 33'(s1_dh_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cor_q  <= s2_cor_d;
      s2_side_q <= s2_side_d;
      s2_ah_q   <= s1_ah_q;
      s2_tdh_q  <= s2_tdh_d;
    end
  end

  // ---------------- stage 3: vector magnitude bound, blended heading ----------------
  always_comb begin
    absy   = s2_cor_q.y[CW-1] ? -s2_cor_q.y : s2_cor_q.y;
    s3_m_d = (s2_cor_q.x[31:0] > absy[31:0]) ? s2_cor_q.x[31:0] : absy[31:0];
    hrnd   = (34'(s2_tdh_q) + 34'sd16384) >>> 15;
    s3_side_d = s2_side_q;
    if (s2_cor_q.mode == MODE_INTERP) begin
      s3_side_d.hd = s2_ah_q + hrnd[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_cor_q  <= s2_cor_q;
      s3_side_q <= s3_side_d;
      s3_m_q    <= s3_m_d;
    end
  end

  // ---------------- stages 4 and 5: normalize vector up to 2^30 ----------------
  always_comb begin
    s4_cor_d = s3_cor_q;
    s4_m_d   = s3_m_q;
    if (s3_cor_q.mode == MODE_LOOKAT) begin
      if (s4_m_d < (32'd1 << 15)) begin
        s4_m_d     = s4_m_d << 16;
        s4_cor_d.x = s4_cor_d.x <<< 16;
        s4_cor_d.y = s4_cor_d.y <<< 16;
      end
      if (s4_m_d < (32'd1 << 23)) begin
        s4_m_d     = s4_m_d << 8;
        s4_cor_d.x = s4_cor_d.x <<< 8;
        s4_cor_d.y = s4_cor_d.y <<< 8;
      end
      if (s4_m_d < (32'd1 << 27)) begin
        s4_m_d     = s4_m_d << 4;
        s4_cor_d.x = s4_cor_d.x <<< 4;
        s4_cor_d.y = s4_cor_d.y <<< 4;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_cor_q  <= s4_cor_d;
      s4_side_q <= s3_side_q;
      s4_m_q    <= s4_m_d;
    end
  end

  always_comb begin
    s5_cor_d = s4_cor_q;
    s5_m_d   = s4_m_q;
    if (s4_cor_q.mode == MODE_LOOKAT) begin
      if (s5_m_d < (32'd1 << 29)) begin
        s5_m_d     = s5_m_d << 2;
        s5_cor_d.x = s5_cor_d.x <<< 2;
        s5_cor_d.y = s5_cor_d.y <<< 2;
      end
      if (s5_m_d < (32'd1 << 30)) begin
        s5_cor_d.x = s5_cor_d.x <<< 1;
        s5_cor_d.y = s5_cor_d.y <<< 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_cor_q  <= s5_cor_d;
      s5_side_q <= s4_side_q;
    end
  end

  // ---------------- CORDIC ----------------
  ppt_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .cor_i  (s5_cor_q),
    .side_i (s5_side_q),
    .vld_o  (cr_vld),
    .cor_o  (cr_cor),
    .side_o (cr_side)
  );

  // ---------------- C1: sin/cos to Q28, bearing to 16 bits ----------------
  always_comb begin
    xf = cr_cor.flip ? -cr_cor.x : cr_cor.x;
    yf = cr_cor.flip ? -cr_cor.y : cr_cor.y;
    cv = (xf + CW'(2)) >>> 2;
    sv = (yf + CW'(2)) >>> 2;
    zs = cr_cor.z + 32'd32768;
    c1_side_d = cr_side;
    if (cr_cor.mode == MODE_INTERP) begin
      c1_c_d = {14'h0000, cr_side.t};
      c1_s_d = '0;
    end else begin
      c1_c_d = cv[29:0];
      c1_s_d = sv[29:0];
    end
    if (cr_cor.mode == MODE_LOOKAT) begin
      c1_side_d.hd = cr_cor.zero ? 16'h0000 : zs[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_mode_q <= cr_cor.mode;
      c1_side_q <= c1_side_d;
      c1_c_q    <= c1_c_d;
      c1_s_q    <= c1_s_d;
    end
  end

  // ---------------- C2: four products ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_mode_q <= c1_mode_q;
      c2_side_q <= c1_side_q;
      c2_cp_q   <= 63'(c1_c_q) * 63'($signed(c1_side_q.p));
      c2_sq_q   <= 63'(c1_s_q) * 63'($signed(c1_side_q.q));
      c2_sp_q   <= 63'(c1_s_q) * 63'($signed(c1_side_q.p));
      c2_cq_q   <= 63'(c1_c_q) * 63'($signed(c1_side_q.q));
    end
  end

  // ---------------- C3: combine and round ----------------
  always_comb begin
    case (c2_mode_q)
      MODE_L2W: begin
        xsum = 64'(c2_cp_q) - 64'(c2_sq_q);
        ysum = 64'(c2_sp_q) + 64'(c2_cq_q);
      end
      MODE_INV: begin
        xsum = 64'(c2_cp_q) + 64'(c2_sq_q);
        ysum = 64'(c2_sp_q) - 64'(c2_cq_q);
      end
      default: begin
        xsum = 64'(c2_cp_q) + 64'(c2_sq_q);
        ysum = 64'(c2_cq_q) - 64'(c2_sp_q);
      end
    endcase
    if (c2_mode_q == MODE_INTERP) begin
      xacc = (xsum + 64'sd16384) >>> 15;
      yacc = (ysum + 64'sd16384) >>> 15;
    end else begin
      xacc = (xsum + 64'sd134217728) >>> 28;
      yacc = (ysum + 64'sd134217728) >>> 28;
    end
    c3_xr_d = xacc[35:0];
    c3_yr_d = yacc[35:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_mode_q <= c2_mode_q;
      c3_side_q <= c2_side_q;
      c3_xr_q   <= c3_xr_d;
      c3_yr_q   <= c3_yr_d;
    end
  end

  // ---------------- C4: offset, negate, saturate ----------------
  always_comb begin
    case (c3_mode_q)
      MODE_L2W, MODE_INTERP: begin
        rxw = 38'(c3_side_q.ax) + 38'(c3_xr_q);
        ryw = 38'(c3_side_q.ay) + 38'(c3_yr_q);
      end
      MODE_W2L: begin
        rxw = 38'(c3_xr_q);
        ryw = 38'(c3_yr_q);
      end
      MODE_INV: begin
        rxw = -38'(c3_xr_q);
        ryw = 38'(c3_yr_q);
      end
      MODE_LOOKAT: begin
        rxw = 38'(c3_side_q.ax);
        ryw = 38'(c3_side_q.ay);
      end
      default: begin
        rxw = '0;
        ryw = '0;
      end
    endcase
    tail_d.hd = c3_side_q.hd;
    tail_d.ov = (rxw > POS_MAX) || (rxw < POS_MIN) || (ryw > POS_MAX) || (ryw < POS_MIN);
    if (rxw > POS_MAX) begin
      tail_d.rx = 32'sh7FFF_FFFF;
    end else if (rxw < POS_MIN) begin
      tail_d.rx = 32'sh8000_0000;
    end else begin
      tail_d.rx = rxw[31:0];
    end
    if (ryw > POS_MAX) begin
      tail_d.ry = 32'sh7FFF_FFFF;
    end else if (ryw < POS_MIN) begin
      tail_d.ry = 32'sh8000_0000;
    end else begin
      tail_d.ry = ryw[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q <= tail_d;
    end
  end

  // ---------------- valid bits of the pipeline ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      s5_vld_q   <= 1'b0;
      c1_vld_q   <= 1'b0;
      c2_vld_q   <= 1'b0;
      c3_vld_q   <= 1'b0;
      tail_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q   <= in_valid_i;
      s2_vld_q   <= s1_vld_q;
      s3_vld_q   <= s2_vld_q;
      s4_vld_q   <= s3_vld_q;
      s5_vld_q   <= s4_vld_q;
      c1_vld_q   <= cr_vld;
      c2_vld_q   <= c1_vld_q;
      c3_vld_q   <= c2_vld_q;
      tail_vld_q <= c3_vld_q;
    end
  end

  // ---------------- output register and skid ----------------
  // advance the output word whenever it is empty or being taken
  assign take = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (tail_vld_q) begin
      if (take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (tail_vld_q) begin
      if (take) begin
        out_q <= tail_q;
      end else begin
        skid_q <= tail_q;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign r_x_o       = out_q.rx;
  assign r_y_o       = out_q.ry;
  assign r_heading_o = out_q.hd;
  assign overflow_o  = out_q.ov;

endmodule

`default_nettype wire
